>>> hw/rtl/tdp_pkg.sv
// tdp_pkg: shared types and constants for the trial-division prime test
// no dependencies

`default_nettype none

package tdp_pkg;

  // sequencer states of the top level
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_RESULT
  } tdp_state_e;

  // first odd trial divisor and its square
  localparam int unsigned FIRST_DIVISOR = 3;
  localparam int unsigned FIRST_SQUARE  = 9;

endpackage

`default_nettype wire

>>> hw/rtl/trial_division_prime_test.sv
// trial_division_prime_test: primality test of a signed candidate by odd trial division
// depends on tdp_pkg and tdp_rem_unit
//
//   channel  signals                                  direction
//   in       in_valid_i, in_ready_o, candidate_i      item in
//   out      out_valid_o, out_ready_i, is_prime_o     item out
//
// Negative, 0, 1, 2 and even candidates resolve on acceptance.
// Odd candidates are tried against each odd divisor d <= sqrt(n) in turn:
// one pass of the bit-serial remainder unit, a step to take the remainder
// and a compare of d^2 against n.
// The worst case is a prime candidate near 2^(VALUE_BITS-1).
// One item is in work at a time; in_ready_o is high only while idle.
// The result register frees the input side while the result waits on out_ready_i.
// Reset is asynchronous active low and clears all control state.

`default_nettype none

module trial_division_prime_test #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] candidate_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  is_prime_o
);

  import tdp_pkg::*;

  localparam int unsigned W = VALUE_BITS;

  tdp_state_e     state_q, state_d;
  logic [W-1:0]   n_q, n_d;
  logic [W-1:0]   d_q, d_d;
  logic [W:0]     sq_q, sq_d;
  logic           verdict_q, verdict_d;
  logic           out_valid_q, out_valid_d;
  logic           out_bit_q, out_bit_d;
  logic           rem_start;
  logic           rem_done;
  logic [W-1:0]   rem_value;
  logic           in_fire;

  assign in_fire = in_valid_i && (state_q == ST_IDLE);

  // shared remainder unit
  tdp_rem_unit #(
    .Width(W)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .done_o     (rem_done),
    .remainder_o(rem_value)
  );

  // sequencer: classify, compare square, divide, deliver
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    d_d         = d_q;
    sq_d        = sq_q;
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q;
    out_bit_d   = out_bit_q;
    rem_start   = 1'b0;

    // result register drains independently
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          n_d  = candidate_i;
          d_d  = W'(FIRST_DIVISOR);
          sq_d = (W + 1)'(FIRST_SQUARE);
          if (candidate_i[W-1]) begin
            verdict_d = 1'b0;
            state_d   = ST_RESULT;
          end else if (candidate_i < W'(2)) begin
            verdict_d = 1'b0;
            state_d   = ST_RESULT;
          end else if (candidate_i == W'(2)) begin
            verdict_d = 1'b1;
            state_d   = ST_RESULT;
          end else if (!candidate_i[0]) begin
            verdict_d = 1'b0;
            state_d   = ST_RESULT;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        // divisor past the square root: no factor found
        if (sq_q > {1'b0, n_q}) begin
          verdict_d = 1'b1;
          state_d   = ST_RESULT;
        end else begin
          rem_start = 1'b1;
          state_d   = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (rem_done) begin
          if (rem_value == '0) begin
            verdict_d = 1'b0;
            state_d   = ST_RESULT;
          end else begin
            // (d+2)^2 = d^2 + 4d + 4
            d_d     = d_q + W'(2);
            sq_d    = sq_q + (W + 1)'({d_q, 2'b00}) + (W + 1)'(4);
            state_d = ST_CHECK;
          end
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_bit_d   = verdict_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    d_q       <= d_d;
    sq_q      <= sq_d;
    verdict_q <= verdict_d;
    out_bit_q <= out_bit_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign is_prime_o  = out_bit_q;

endmodule

`default_nettype wire

>>> hw/rtl/tdp_rem_unit.sv
// tdp_rem_unit: restoring remainder unit, one quotient bit per cycle
// no dependencies; used by trial_division_prime_test

`default_nettype none

module tdp_rem_unit #(
  parameter int unsigned Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             done_o,
  output logic [Width-1:0] remainder_o
);

  localparam int unsigned CntBits = $clog2(Width + 1);

  logic               busy_q;
  logic               done_q;
  logic [CntBits-1:0] cnt_q;
  logic [Width-1:0]   dvd_q;
  logic [Width-1:0]   dvs_q;
  logic [Width-1:0]   rem_q;
  logic [Width:0]     trial;
  logic [Width:0]     diff;
  logic               fits;

  // shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem_q, dvd_q[Width-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = trial >= {1'b0, dvs_q};
  end

  // control: bit counter, busy and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntBits'(Width);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath: partial remainder and dividend shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[Width-1:0] : trial[Width-1:0];
      dvd_q <= {dvd_q[Width-2:0], 1'b0};
    end
  end

  assign done_o      = done_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire
